[hw/rtl/seconds_to_calendar_core_assert.svh]
// Assertion macros shared by the calendar conversion RTL
`ifndef SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`ifndef SYNTH
`define S2C_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("s2c assertion failed");
`define S2C_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("s2c assertion failed");
`else
`define S2C_ASSERT_IMP(name, pre, post)
`define S2C_ASSERT_NXT(name, pre, post)
`endif
`endif

[hw/rtl/s2c_pkg.sv]
// Widths, calendar constants and month tables for the calendar conversion core
package s2c_pkg;
	localparam int SecW   = 37;
	localparam int YearW  = 13;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int WdayW  = 3;
	localparam int DoyW   = 9;
	localparam int CalcW  = 37;
	localparam int QuoW   = 21;
	localparam int StepW  = 5;
	localparam int SodW   = 17;
	localparam int CentW  = 6;
	localparam int KW     = 7;
	localparam int N100W  = 2;
	localparam int N4W    = 5;
	localparam int ZsumW  = 9;
	localparam int ZtermW = 6;

	localparam int StepsDay  = 21;
	localparam int StepsY400 = 4;
	localparam int StepsY100 = 2;
	localparam int StepsY4   = 5;
	localparam int StepsY1   = 2;
	localparam int StepsHour = 5;
	localparam int StepsMin  = 6;
	localparam int StepsZdiv = 6;
	localparam int StepsZmod = 6;

	localparam logic [CalcW-1:0] SecsPerDay  = CalcW'(86400);
	localparam logic [CalcW-1:0] SecsPerHour = CalcW'(3600);
	localparam logic [CalcW-1:0] SecsPerMin  = CalcW'(60);
	localparam logic [CalcW-1:0] DaysPer400  = CalcW'(146097);
	localparam logic [CalcW-1:0] DaysPer100  = CalcW'(36524);
	localparam logic [CalcW-1:0] DaysPer4    = CalcW'(1461);
	localparam logic [CalcW-1:0] DaysPer1    = CalcW'(365);
	localparam logic [CalcW-1:0] YearsPerCent = CalcW'(100);
	localparam logic [CalcW-1:0] DaysPerWeek = CalcW'(7);

	localparam logic [YearW-1:0] Weight400 = YearW'(400);
	localparam logic [YearW-1:0] Weight100 = YearW'(100);
	localparam logic [YearW-1:0] Weight4   = YearW'(4);
	localparam logic [YearW-1:0] Weight1   = YearW'(1);

	localparam logic [MonthW-1:0] MonJan = MonthW'(1);
	localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
	localparam logic [MonthW-1:0] MonMar = MonthW'(3);
	localparam logic [MonthW-1:0] MonDec = MonthW'(12);
	localparam logic [MonthW-1:0] MonthsPerYear = MonthW'(12);

	localparam logic [N100W-1:0] LastCent  = N100W'(3);
	localparam logic [N4W-1:0]   LastQuad  = N4W'(24);
	localparam logic [N100W-1:0] LastYear  = N100W'(3);

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		case (m)
			4'd2:                      month_len = leap ? DayW'(29) : DayW'(28);
			4'd4, 4'd6, 4'd9, 4'd11:   month_len = DayW'(30);
			default:                   month_len = DayW'(31);
		endcase
	endfunction

	function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m, input logic leap);
		logic [DoyW-1:0] base;
		case (m)
			4'd2:    base = DoyW'(31);
			4'd3:    base = DoyW'(59);
			4'd4:    base = DoyW'(90);
			4'd5:    base = DoyW'(120);
			4'd6:    base = DoyW'(151);
			4'd7:    base = DoyW'(181);
			4'd8:    base = DoyW'(212);
			4'd9:    base = DoyW'(243);
			4'd10:   base = DoyW'(273);
			4'd11:   base = DoyW'(304);
			4'd12:   base = DoyW'(334);
			default: base = '0;
		endcase
		cum_days = base + DoyW'(leap && (m >= MonMar));
	endfunction

	function automatic logic [ZtermW-1:0] zeller_term(input logic [MonthW-1:0] mm);
		case (mm)
			4'd3:    zeller_term = ZtermW'(10);
			4'd4:    zeller_term = ZtermW'(13);
			4'd5:    zeller_term = ZtermW'(15);
			4'd6:    zeller_term = ZtermW'(18);
			4'd7:    zeller_term = ZtermW'(20);
			4'd8:    zeller_term = ZtermW'(23);
			4'd9:    zeller_term = ZtermW'(26);
			4'd10:   zeller_term = ZtermW'(28);
			4'd11:   zeller_term = ZtermW'(31);
			4'd12:   zeller_term = ZtermW'(33);
			4'd13:   zeller_term = ZtermW'(36);
			4'd14:   zeller_term = ZtermW'(39);
			default: zeller_term = '0;
		endcase
	endfunction
endpackage

[hw/rtl/seconds_to_calendar_core.sv]
// Seconds-since-year-one to Gregorian calendar conversion core.
// done rises once the month walk and the Zeller weekday steps are through; the result beat
// is shown in that done cycle.
// New input is taken only in idle; one compare-subtract unit does every division and walk.
// Reset: arst_n low clears the sequencer to idle at once; result registers are not cleared.
// Results are shown for the single done cycle and cannot be stalled.
`include "seconds_to_calendar_core_assert.svh"
module seconds_to_calendar_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	output logic                       done,
	input  logic [s2c_pkg::SecW-1:0]   total_seconds,
	output logic [s2c_pkg::YearW-1:0]  year_out,
	output logic [s2c_pkg::MonthW-1:0] month_out,
	output logic [s2c_pkg::DayW-1:0]   day_out,
	output logic [s2c_pkg::HourW-1:0]  hour_out,
	output logic [s2c_pkg::MinW-1:0]   minute_out,
	output logic [s2c_pkg::MinW-1:0]   second_out,
	output logic [s2c_pkg::WdayW-1:0]  weekday_out,
	output logic [s2c_pkg::DoyW-1:0]   day_of_year,
	output logic                       day_valid
);
	import s2c_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DAY   = 13'b0000000000010,
		S_Y400  = 13'b0000000000100,
		S_Y100  = 13'b0000000001000,
		S_Y4    = 13'b0000000010000,
		S_Y1    = 13'b0000000100000,
		S_HOUR  = 13'b0000001000000,
		S_MIN   = 13'b0000010000000,
		S_MONTH = 13'b0000100000000,
		S_ZDIV  = 13'b0001000000000,
		S_ZSUM  = 13'b0010000000000,
		S_ZMOD  = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t              state_q;
	logic [StepW-1:0]    step_q;
	logic [CalcW-1:0]    rem_q;
	logic [QuoW-1:0]     quo_q;
	logic [SodW-1:0]     sod_q;
	logic [YearW-1:0]    year_q;
	logic [N100W-1:0]    n100_q;
	logic [N4W-1:0]      n4_q;
	logic [DoyW-1:0]     days_q;
	logic                leap_q;
	logic [HourW-1:0]    hour_q;
	logic [MinW-1:0]     minute_q;
	logic [MinW-1:0]     second_q;
	logic [MonthW-1:0]   month_q;
	logic [DayW-1:0]     dom_q;
	logic [MonthW-1:0]   mm_q;
	logic [CentW-1:0]    j_q;
	logic [KW-1:0]       k_q;
	logic [WdayW-1:0]    weekday_q;

	logic [CalcW-1:0]    div_base;
	logic [CalcW-1:0]    divisor;
	logic [CalcW-1:0]    diff;
	logic                ge;
	logic [CalcW-1:0]    rem_nx;
	logic [QuoW-1:0]     quo_nx;
	logic [YearW-1:0]    yr_weight;
	logic [YearW-1:0]    yr_inc;
	logic                month_adv;
	logic                early_month;
	logic [YearW-1:0]    zyear;
	logic [ZsumW-1:0]    j5;
	logic [ZsumW-1:0]    zsum;

	always_comb begin
		case (state_q)
			S_DAY:   div_base = SecsPerDay;
			S_Y400:  div_base = DaysPer400;
			S_Y100:  div_base = DaysPer100;
			S_Y4:    div_base = DaysPer4;
			S_Y1:    div_base = DaysPer1;
			S_HOUR:  div_base = SecsPerHour;
			S_MIN:   div_base = SecsPerMin;
			S_MONTH: div_base = CalcW'(month_len(month_q, leap_q));
			S_ZDIV:  div_base = YearsPerCent;
			S_ZMOD:  div_base = DaysPerWeek;
			default: div_base = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_Y400:  yr_weight = Weight400;
			S_Y100:  yr_weight = Weight100;
			S_Y4:    yr_weight = Weight4;
			S_Y1:    yr_weight = Weight1;
			default: yr_weight = '0;
		endcase
	end

	assign divisor = div_base << step_q;
	assign yr_inc  = yr_weight << step_q;

	s2c_cmp_sub u_cmp_sub (
		.a    (rem_q),
		.b    (divisor),
		.diff (diff),
		.ge   (ge)
	);

	assign rem_nx      = ge ? diff : rem_q;
	assign quo_nx      = {quo_q[QuoW-2:0], ge};
	assign month_adv   = (month_q != MonDec) && ge && (diff != '0);
	assign early_month = (month_q <= MonFeb);
	assign zyear       = early_month ? (year_q - Weight1) : year_q;
	assign j5          = {1'b0, j_q, 2'b00} + ZsumW'(j_q);
	assign zsum        = ZsumW'(dom_q) + ZsumW'(zeller_term(mm_q)) + ZsumW'(k_q)
			+ ZsumW'(k_q[KW-1:2]) + ZsumW'(j_q[CentW-1:2]) + j5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DAY;
						step_q  <= StepW'(StepsDay - 1);
					end
				end
				S_DAY: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_Y400;
						step_q  <= StepW'(StepsY400 - 1);
					end
				end
				S_Y400: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_Y100;
						step_q  <= StepW'(StepsY100 - 1);
					end
				end
				S_Y100: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_Y4;
						step_q  <= StepW'(StepsY4 - 1);
					end
				end
				S_Y4: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_Y1;
						step_q  <= StepW'(StepsY1 - 1);
					end
				end
				S_Y1: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_HOUR;
						step_q  <= StepW'(StepsHour - 1);
					end
				end
				S_HOUR: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_MIN;
						step_q  <= StepW'(StepsMin - 1);
					end
				end
				S_MIN: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_MONTH;
						step_q  <= '0;
					end
				end
				S_MONTH: begin
					if (!month_adv) begin
						state_q <= S_ZDIV;
						step_q  <= StepW'(StepsZdiv - 1);
					end
				end
				S_ZDIV: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_ZSUM;
						step_q  <= '0;
					end
				end
				S_ZSUM: begin
					state_q <= S_ZMOD;
					step_q  <= StepW'(StepsZmod - 1);
				end
				S_ZMOD: begin
					if (step_q != '0) step_q <= step_q - 1'b1;
					else begin
						state_q <= S_DONE;
						step_q  <= '0;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) rem_q <= CalcW'(total_seconds);
			end
			S_DAY: begin
				quo_q <= quo_nx;
				if (step_q == '0) begin
					rem_q  <= CalcW'(quo_nx);
					sod_q  <= rem_nx[SodW-1:0];
					year_q <= Weight1;
				end else begin
					rem_q <= rem_nx;
				end
			end
			S_Y400: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (ge) year_q <= year_q + yr_inc;
			end
			S_Y100: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (ge) year_q <= year_q + yr_inc;
				if (step_q == '0) n100_q <= quo_nx[N100W-1:0];
			end
			S_Y4: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (ge) year_q <= year_q + yr_inc;
				if (step_q == '0) n4_q <= quo_nx[N4W-1:0];
			end
			S_Y1: begin
				quo_q <= quo_nx;
				if (ge) year_q <= year_q + yr_inc;
				if (step_q == '0) begin
					days_q <= rem_nx[DoyW-1:0];
					leap_q <= (quo_nx[N100W-1:0] == LastYear)
							&& ((n4_q != LastQuad) || (n100_q == LastCent));
					rem_q  <= CalcW'(sod_q);
				end else begin
					rem_q <= rem_nx;
				end
			end
			S_HOUR: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (step_q == '0) hour_q <= quo_nx[HourW-1:0];
			end
			S_MIN: begin
				quo_q <= quo_nx;
				if (step_q == '0) begin
					minute_q <= quo_nx[MinW-1:0];
					second_q <= rem_nx[MinW-1:0];
					rem_q    <= CalcW'(days_q);
					month_q  <= MonJan;
				end else begin
					rem_q <= rem_nx;
				end
			end
			S_MONTH: begin
				if (month_adv) begin
					rem_q   <= diff;
					month_q <= month_q + 1'b1;
				end else begin
					dom_q <= rem_q[DayW-1:0];
					rem_q <= CalcW'(zyear);
					mm_q  <= early_month ? (month_q + MonthsPerYear) : month_q;
				end
			end
			S_ZDIV: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (step_q == '0) begin
					j_q <= quo_nx[CentW-1:0];
					k_q <= rem_nx[KW-1:0];
				end
			end
			S_ZSUM: begin
				rem_q <= CalcW'(zsum);
			end
			S_ZMOD: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
				if (step_q == '0) weekday_q <= rem_nx[WdayW-1:0];
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign year_out    = year_q;
	assign month_out   = month_q;
	assign day_out     = dom_q;
	assign hour_out    = hour_q;
	assign minute_out  = minute_q;
	assign second_out  = second_q;
	assign weekday_out = weekday_q;
	assign day_of_year = cum_days(month_q, leap_q) + DoyW'(dom_q);
	assign day_valid   = (dom_q != '0);

	`S2C_ASSERT_NXT(a_accept_runs, start && !busy, busy && !done)
	`S2C_ASSERT_NXT(a_done_returns_idle, done, !busy && !done)
	`S2C_ASSERT_IMP(a_time_in_range, done, (hour_out <= 5'd23) && (minute_out <= 6'd59) && (second_out <= 6'd59))
	`S2C_ASSERT_IMP(a_date_in_range, done, (month_out >= MonJan) && (month_out <= MonDec) && (weekday_out <= 3'd6))
	`S2C_ASSERT_IMP(a_year_nonzero, done, (year_out != '0) && (day_of_year <= 9'd366))
endmodule

[hw/rtl/s2c_cmp_sub.sv]
// Shared compare-and-subtract unit used for every division and walk step
module s2c_cmp_sub (
	input  logic [s2c_pkg::CalcW-1:0] a,
	input  logic [s2c_pkg::CalcW-1:0] b,
	output logic [s2c_pkg::CalcW-1:0] diff,
	output logic                      ge
);
	import s2c_pkg::*;

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = !borrow;
endmodule

[bench/seconds_to_calendar_core_checker.sv]
`timescale 1ns / 1ps
// Checker for the calendar core: predicts each conversion and compares every result beat
module seconds_to_calendar_core_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       done,
	input  logic [s2c_pkg::SecW-1:0]   total_seconds,
	input  logic [s2c_pkg::YearW-1:0]  year_out,
	input  logic [s2c_pkg::MonthW-1:0] month_out,
	input  logic [s2c_pkg::DayW-1:0]   day_out,
	input  logic [s2c_pkg::HourW-1:0]  hour_out,
	input  logic [s2c_pkg::MinW-1:0]   minute_out,
	input  logic [s2c_pkg::MinW-1:0]   second_out,
	input  logic [s2c_pkg::WdayW-1:0]  weekday_out,
	input  logic [s2c_pkg::DoyW-1:0]   day_of_year,
	input  logic                       day_valid,
	output int                         fail_count,
	output int                         pending
);
	import s2c_pkg::*;

	localparam longint unsigned DaySecs      = 86400;
	localparam longint unsigned CommonSecs   = 365 * DaySecs;
	localparam longint unsigned LeapYearSecs = 366 * DaySecs;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [HourW-1:0]  hour;
		logic [MinW-1:0]   minute;
		logic [MinW-1:0]   second;
		logic [WdayW-1:0]  weekday;
		logic [DoyW-1:0]   yday;
		logic              day_ok;
	} cal_fields_t;

	cal_fields_t pending_dates[$];

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in(input int unsigned mon, input bit leap);
		case (mon)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic cal_fields_t calendar_of(input logic [SecW-1:0] secs);
		cal_fields_t  f;
		longint unsigned rem;
		int unsigned  yr;
		int unsigned  mon;
		int unsigned  dd;
		int unsigned  yday;
		int unsigned  zy;
		int unsigned  zm;
		int unsigned  k;
		int unsigned  j;
		bit           leap;
		rem = secs;
		yr = 1;
		while (rem >= CommonSecs && !(is_leap(yr) && rem < LeapYearSecs)) begin
			rem -= is_leap(yr) ? LeapYearSecs : CommonSecs;
			yr++;
		end
		leap = is_leap(yr);
		dd = rem / DaySecs;
		yday = 0;
		mon = 1;
		while (mon < 12 && dd > days_in(mon, leap)) begin
			dd -= days_in(mon, leap);
			yday += days_in(mon, leap);
			mon++;
		end
		yday += dd;
		zy = yr;
		zm = mon;
		if (zm <= 2) begin
			zm += 12;
			zy = (zy > 0) ? zy - 1 : 0;
		end
		k = zy % 100;
		j = zy / 100;
		f.year    = YearW'(yr);
		f.month   = MonthW'(mon);
		f.day     = DayW'(dd);
		f.hour    = HourW'((rem / 3600) % 24);
		f.minute  = MinW'((rem / 60) % 60);
		f.second  = MinW'(rem % 60);
		f.weekday = WdayW'((dd + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
		f.yday    = DoyW'(yday);
		f.day_ok  = (dd >= 1);
		return f;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		cal_fields_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_dates.push_back(calendar_of(total_seconds));
			if (done) begin
				if (pending_dates.size() == 0) begin
					$error("result beat with no conversion outstanding");
					fail_count++;
				end else begin
					want = pending_dates.pop_front();
					check_field("year_out", want.year, year_out);
					check_field("month_out", want.month, month_out);
					check_field("day_out", want.day, day_out);
					check_field("hour_out", want.hour, hour_out);
					check_field("minute_out", want.minute, minute_out);
					check_field("second_out", want.second, second_out);
					check_field("weekday_out", want.weekday, weekday_out);
					check_field("day_of_year", want.yday, day_of_year);
					check_field("day_valid", want.day_ok, day_valid);
				end
			end
			pending = pending_dates.size();
		end
	end
endmodule

[bench/seconds_to_calendar_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the calendar core: clock, reset, conversion stimulus and verdict
module seconds_to_calendar_core_tb;
	import s2c_pkg::*;

	localparam longint unsigned DaySecs    = 86400;
	localparam longint unsigned CommonSecs = 365 * DaySecs;
	localparam longint unsigned MaxSecs    = (64'd1 << SecW) - 1;
	localparam int unsigned     LastYear   = 4356;
	localparam int              RandomBeats = 1000;
	localparam int              WatchLimit = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [SecW-1:0]   total_seconds = '0;
	logic              busy;
	logic              done;
	logic [YearW-1:0]  year_out;
	logic [MonthW-1:0] month_out;
	logic [DayW-1:0]   day_out;
	logic [HourW-1:0]  hour_out;
	logic [MinW-1:0]   minute_out;
	logic [MinW-1:0]   second_out;
	logic [WdayW-1:0]  weekday_out;
	logic [DoyW-1:0]   day_of_year;
	logic              day_valid;
	int                fail_count;
	int                pending;
	int                stall_cycles = 0;
	int unsigned       burst_left = 0;

	seconds_to_calendar_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.done         (done),
		.total_seconds(total_seconds),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.second_out   (second_out),
		.weekday_out  (weekday_out),
		.day_of_year  (day_of_year),
		.day_valid    (day_valid)
	);

	seconds_to_calendar_core_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.done         (done),
		.total_seconds(total_seconds),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.second_out   (second_out),
		.weekday_out  (weekday_out),
		.day_of_year  (day_of_year),
		.day_valid    (day_valid),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WatchLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint unsigned year_start(input int unsigned y);
		longint unsigned n;
		n = y - 1;
		return (365 * n + n / 4 - n / 100 + n / 400) * DaySecs;
	endfunction

	function automatic longint unsigned pick_seconds();
		longint unsigned v;
		int unsigned     y;
		y = $urandom_range(LastYear, 1);
		if ($urandom_range(1, 0) == 0)
			y = y & ~32'd3;
		if (y == 0)
			y = 4;
		case ($urandom_range(9, 0))
			0, 1, 2, 3: v = (longint'($urandom_range(31, 0)) << 32) | longint'($urandom);
			4, 5: v = year_start(y) + $urandom_range(2 * DaySecs - 1, 0);
			6: v = year_start(y + 1) - 1 - $urandom_range(2 * DaySecs, 0);
			7: v = year_start(y) + $urandom_range(62, 27) * DaySecs + $urandom_range(DaySecs - 1, 0);
			8: v = $urandom_range(5 * CommonSecs, 0);
			default: v = year_start(y) + $urandom_range(365, 0) * DaySecs +
				($urandom_range(1, 0) ? DaySecs - 1 - $urandom_range(60, 0) : $urandom_range(60, 0));
		endcase
		return (v > MaxSecs) ? MaxSecs : v;
	endfunction

	task automatic send_conversion(input longint unsigned secs);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(90, 1);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		total_seconds <= SecW'(secs);
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		longint unsigned corner[$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner.push_back(0);
		corner.push_back(59);
		corner.push_back(3599);
		corner.push_back(DaySecs - 1);
		corner.push_back(DaySecs);
		corner.push_back(31 * DaySecs);
		corner.push_back(32 * DaySecs);
		corner.push_back(59 * DaySecs);
		corner.push_back(60 * DaySecs);
		corner.push_back(CommonSecs - 1);
		corner.push_back(CommonSecs);
		corner.push_back(year_start(4) + 60 * DaySecs);
		corner.push_back(year_start(4) + 365 * DaySecs);
		corner.push_back(year_start(5) - 1);
		corner.push_back(year_start(5));
		corner.push_back(year_start(100) + 60 * DaySecs);
		corner.push_back(year_start(101) - 1);
		corner.push_back(year_start(400) + 60 * DaySecs);
		corner.push_back(year_start(401) - 1);
		corner.push_back(year_start(2000) + 334 * DaySecs + DaySecs - 1);
		corner.push_back(64'h15_5555_5555);
		corner.push_back(64'h0A_AAAA_AAAA);
		corner.push_back(MaxSecs - 1);
		corner.push_back(MaxSecs);
		foreach (corner[i])
			send_conversion(corner[i]);

		repeat (RandomBeats)
			send_conversion(pick_seconds());

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
